### design/mou_pkg.sv
// Package for the multiplicative order unit: widths, status and operation codes, defaults.
// No dependencies.
package mou_pkg;
   localparam int DefaultWidth = 32;
   localparam int InWidth = 32;
   localparam int OrderWidth = 32;
   localparam int StatusWidth = 2;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK          = 2'd0,
      ST_NOT_COPRIME = 2'd1,
      ST_SMALL_MOD   = 2'd2
   } status_type;

   // Operation codes for the shared arithmetic unit
   typedef enum logic [1:0] {
      OP_DIVMOD = 2'd0,
      OP_MULMOD = 2'd1
   } op_type;
endpackage

### design/multiplicative_order_unit.sv
// Top level of the multiplicative order unit: sequencer around mou_alu.
// Depends on mou_pkg and mou_alu.
//
//  channel | ports                         | direction
//  req     | req_valid/ready, base, modulus| in
//  rsp     | rsp_valid/ready, order, status| out
//
// In one transaction the gcd loop, the totient loop, the trial division of
// the totient and the square-and-multiply exponentiations all run through
// the shared unit in turn; every divide or modular multiply holds it until
// the unit reports done.
// Reset is synchronous; it returns the sequencer to idle. req_ready is high
// only in idle with no result waiting; a pending result waits in the output
// register under stall.
module multiplicative_order_unit import mou_pkg::*; #(
   parameter int WIDTH = DefaultWidth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [InWidth-1:0]     req_base,
   input  logic [InWidth-1:0]     req_modulus,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OrderWidth-1:0]  rsp_order,
   output logic [StatusWidth-1:0] rsp_status
);
   localparam int VW = (WIDTH < InWidth) ? WIDTH : InWidth;

   typedef enum logic [4:0] {
      S_IDLE, S_GCD_DIV, S_GCD_W,
      S_PHI_TEST, S_PHI_TEST_W, S_PHI_MOD_W, S_PHI_STRIP_W, S_PHI_A_W,
      S_PHI_NEXT, S_PHI_LAST_W,
      S_F_TEST, S_F_TEST_W, S_F_MOD_W, S_F_EXP_W, S_F_NEXT, S_F_LAST_W,
      S_PW_START, S_PW_MUL_W, S_PW_SQ, S_PW_SQ_W, S_PW_DONE,
      S_DIVC_W, S_RESP
   } state_type;

   state_type     state_ff;
   logic          ret_last_ff;   // exponent check for leftover factor
   logic [VW-1:0] b_ff, m_ff, x_ff, y_ff;
   logic [VW-1:0] v_ff, acc_ff, d_ff, t_ff;
   logic [VW-1:0] cand_ff, rest_ff, f_ff, e_ff, pb_ff, pr_ff;
   logic [VW:0]   ebits_ff;
   logic          rsp_valid_ff;
   logic [OrderWidth-1:0]  order_ff;
   logic [StatusWidth-1:0] status_ff;

   logic          alu_start;
   op_type        alu_op;
   logic [VW-1:0] alu_a, alu_b, alu_m, alu_q, alu_r;
   logic          alu_done;

   mou_alu #(.WIDTH(VW)) u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(alu_op),
      .a(alu_a), .b(alu_b), .m(alu_m), .done(alu_done), .quo(alu_q), .rem(alu_r)
   );

   // Operand registers feed the unit; start pulses from the sequencer
   logic          go_ff;
   op_type        gop_ff;
   logic [VW-1:0] ga_ff, gb_ff, gm_ff;
   assign alu_start = go_ff;
   assign alu_op    = gop_ff;
   assign alu_a     = ga_ff;
   assign alu_b     = gb_ff;
   assign alu_m     = gm_ff;

   assign req_ready  = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_order  = order_ff;
   assign rsp_status = status_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      go_ff <= 1'b0;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ret_last_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  b_ff <= req_base[VW-1:0];
                  m_ff <= req_modulus[VW-1:0];
                  x_ff <= req_base[VW-1:0];
                  y_ff <= req_modulus[VW-1:0];
                  if (req_modulus[VW-1:0] < VW'(2)) begin
                     order_ff  <= '0;
                     status_ff <= ST_SMALL_MOD;
                     state_ff  <= S_RESP;
                  end else begin
                     state_ff <= S_GCD_DIV;
                  end
               end
            end
            // Euclid: x, y -> y, x mod y
            S_GCD_DIV: begin
               if (y_ff == '0) begin
                  if (x_ff != VW'(1)) begin
                     order_ff  <= '0;
                     status_ff <= ST_NOT_COPRIME;
                     state_ff  <= S_RESP;
                  end else begin
                     v_ff     <= m_ff;
                     acc_ff   <= m_ff;
                     d_ff     <= VW'(2);
                     state_ff <= S_PHI_TEST;
                  end
               end else begin
                  go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= x_ff; gb_ff <= y_ff;
                  state_ff <= S_GCD_W;
               end
            end
            S_GCD_W: if (alu_done) begin
               x_ff <= y_ff; y_ff <= alu_r; state_ff <= S_GCD_DIV;
            end
            // Totient loop: d <= v / d ?
            S_PHI_TEST: begin
               go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= v_ff; gb_ff <= d_ff;
               state_ff <= S_PHI_TEST_W;
            end
            S_PHI_TEST_W: if (alu_done) begin
               if (d_ff > alu_q) begin
                  if (v_ff > VW'(1)) begin
                     go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= acc_ff; gb_ff <= v_ff;
                     state_ff <= S_PHI_LAST_W;
                  end else begin
                     cand_ff <= acc_ff; rest_ff <= acc_ff; f_ff <= VW'(2);
                     state_ff <= S_F_TEST;
                  end
               end else if (alu_r == '0) begin
                  t_ff <= alu_q;
                  go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= acc_ff; gb_ff <= d_ff;
                  state_ff <= S_PHI_A_W;
               end else begin
                  state_ff <= S_PHI_NEXT;
               end
            end
            S_PHI_A_W: if (alu_done) begin
               // acc/d*(d-1) = acc/d*d - acc/d, acc/d*d == acc since d | acc
               acc_ff <= acc_ff - alu_q;
               v_ff   <= t_ff;
               go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= t_ff; gb_ff <= d_ff;
               state_ff <= S_PHI_STRIP_W;
            end
            S_PHI_STRIP_W: if (alu_done) begin
               if (alu_r == '0) begin
                  v_ff <= alu_q;
                  go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= alu_q; gb_ff <= d_ff;
               end else begin
                  state_ff <= S_PHI_NEXT;
               end
            end
            S_PHI_MOD_W: state_ff <= S_PHI_NEXT;
            S_PHI_NEXT: begin
               d_ff <= d_ff + VW'(1); state_ff <= S_PHI_TEST;
            end
            S_PHI_LAST_W: if (alu_done) begin
               cand_ff <= acc_ff - alu_q; rest_ff <= acc_ff - alu_q; f_ff <= VW'(2);
               state_ff <= S_F_TEST;
            end
            // Factor the totient, trying each factor on the candidate
            S_F_TEST: begin
               go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= rest_ff; gb_ff <= f_ff;
               state_ff <= S_F_TEST_W;
            end
            S_F_TEST_W: if (alu_done) begin
               if (f_ff > alu_q) begin
                  if (rest_ff > VW'(1)) begin
                     ret_last_ff <= 1'b1;
                     go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= cand_ff; gb_ff <= rest_ff;
                     state_ff <= S_F_LAST_W;
                  end else begin
                     order_ff  <= OrderWidth'(cand_ff);
                     status_ff <= ST_OK;
                     state_ff  <= S_RESP;
                  end
               end else if (alu_r == '0) begin
                  rest_ff <= alu_q;
                  ret_last_ff <= 1'b0;
                  go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= cand_ff; gb_ff <= f_ff;
                  state_ff <= S_F_MOD_W;
               end else begin
                  state_ff <= S_F_NEXT;
               end
            end
            S_F_MOD_W: if (alu_done) begin
               e_ff <= alu_q; t_ff <= alu_q; state_ff <= S_PW_START;
            end
            S_F_LAST_W: if (alu_done) begin
               e_ff <= alu_q; t_ff <= alu_q; state_ff <= S_PW_START;
            end
            S_F_NEXT: begin
               f_ff <= f_ff + VW'(1); state_ff <= S_F_TEST;
            end
            // Square-and-multiply, LSB first
            S_PW_START: begin
               pr_ff    <= (m_ff == VW'(1)) ? '0 : VW'(1);
               pb_ff    <= b_ff;
               ebits_ff <= {1'b0, e_ff};
               // reduce base: b mod m
               go_ff <= 1'b1; gop_ff <= OP_DIVMOD; ga_ff <= b_ff; gb_ff <= m_ff;
               state_ff <= S_PW_SQ_W;
               x_ff <= '0; // marks base reduction
            end
            S_PW_SQ: begin
               if (ebits_ff == '0) begin
                  state_ff <= S_PW_DONE;
               end else if (ebits_ff[0]) begin
                  go_ff <= 1'b1; gop_ff <= OP_MULMOD; ga_ff <= pr_ff; gb_ff <= pb_ff;
                  gm_ff <= m_ff;
                  state_ff <= S_PW_MUL_W;
               end else begin
                  go_ff <= 1'b1; gop_ff <= OP_MULMOD; ga_ff <= pb_ff; gb_ff <= pb_ff;
                  gm_ff <= m_ff;
                  x_ff <= VW'(1);
                  state_ff <= S_PW_SQ_W;
               end
            end
            S_PW_MUL_W: if (alu_done) begin
               pr_ff <= alu_r;
               go_ff <= 1'b1; gop_ff <= OP_MULMOD; ga_ff <= pb_ff; gb_ff <= pb_ff;
               gm_ff <= m_ff;
               x_ff <= VW'(1);
               state_ff <= S_PW_SQ_W;
            end
            S_PW_SQ_W: if (alu_done) begin
               if (x_ff == '0) begin
                  pb_ff <= alu_r;
               end else begin
                  pb_ff    <= alu_r;
                  ebits_ff <= ebits_ff >> 1;
               end
               state_ff <= S_PW_SQ;
            end
            S_PW_DONE: begin
               if (pr_ff == VW'(1)) begin
                  cand_ff <= t_ff;
               end
               if (ret_last_ff) begin
                  order_ff  <= OrderWidth'((pr_ff == VW'(1)) ? t_ff : cand_ff);
                  status_ff <= ST_OK;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_F_TEST; // same factor again
               end
            end
            S_DIVC_W: state_ff <= S_F_TEST;
            S_RESP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### design/mou_alu.sv
// Shared multi-cycle arithmetic unit: restoring divide (quotient, remainder)
// and shift-and-add modular multiply, one bit per cycle. Uses mou_pkg.
module mou_alu import mou_pkg::*; #(
   parameter int WIDTH = DefaultWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  op_type           op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic [WIDTH-1:0] m,
   output logic             done,
   output logic [WIDTH-1:0] quo,
   output logic [WIDTH-1:0] rem
);
   localparam int CntWidth = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   op_type           op_ff, op_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] q_ff, q_in;     // dividend bits / multiplier bits
   logic [WIDTH-1:0] r_ff, r_in;     // partial remainder / accumulator
   logic [WIDTH-1:0] d_ff, d_in;     // divisor / modulus
   logic [WIDTH-1:0] x_ff, x_in;     // multiplicand
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   acc2;
   logic [WIDTH:0]   sum;

   // Operand load on start, else one step of the selected operation
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      x_in    = x_ff;
      trial   = '0;
      acc2    = '0;
      sum     = '0;
      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         cnt_in  = CntWidth'(WIDTH);
         q_in    = (op == OP_DIVMOD) ? a : b;
         r_in    = '0;
         d_in    = (op == OP_DIVMOD) ? b : m;
         x_in    = a;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_DIVMOD: begin
               trial = {r_ff, q_ff[WIDTH-1]};
               q_in  = {q_ff[WIDTH-2:0], 1'b0};
               if (trial >= {1'b0, d_ff}) begin
                  r_in  = WIDTH'(trial - {1'b0, d_ff});
                  q_in[0] = 1'b1;
               end else begin
                  r_in = trial[WIDTH-1:0];
               end
            end
            default: begin
               // MSB-first Horner: acc = 2*acc (+ x), reduced each time
               acc2 = {r_ff, 1'b0};
               if (acc2 >= {1'b0, d_ff}) acc2 = acc2 - {1'b0, d_ff};
               sum = acc2;
               if (q_ff[WIDTH-1]) begin
                  sum = acc2 + {1'b0, x_ff};
                  if (sum >= {1'b0, d_ff}) sum = sum - {1'b0, d_ff};
               end
               r_in = sum[WIDTH-1:0];
               q_in = {q_ff[WIDTH-2:0], 1'b0};
            end
         endcase
         cnt_in = cnt_ff - CntWidth'(1);
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIVMOD;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      x_ff <= x_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule
